// ===== rtl/svt_pkg.sv =====
// shared types and constants for the sensor voltage to temperature pipeline
package svt_pkg;

  localparam int unsigned CODE_W       = 12;
  localparam int unsigned MV_W         = 12;
  localparam int unsigned TEMP_W       = 12;
  localparam int unsigned DISC_W       = 32;
  localparam int unsigned ROOT_W       = 17;
  localparam int unsigned SQRT_STEPS   = DISC_W / 2;
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned BACK_STAGES  = 6;
  localparam int unsigned LATENCY      = FRONT_STAGES + SQRT_STEPS + BACK_STAGES;

  // millivolt scaling: code * 3220 / 4095
  localparam logic [11:0] MV_SCALE = 12'd3220;

  // discriminant in q24: K0 - K1 * mv
  localparam logic [31:0] DISC_K0 = 32'd2402793751;
  localparam logic [17:0] DISC_K1 = 18'd232868;

  // linear coefficient in q24
  localparam logic [28:0] A_Q24 = 29'd182670328;

  // temperature: round(num * 10^6 / (694 * 2^24))
  localparam logic [19:0] TEMP_SCALE  = 20'd1000000;
  localparam logic [8:0]  TEMP_HALF   = 9'd347;
  localparam logic [9:0]  TEMP_DIV    = 10'd694;
  localparam logic [23:0] TEMP_RECIP  = 24'd12377427;
  localparam int unsigned RECIP_SHIFT = 33;

  localparam logic signed [17:0] TEMP_OFFSET = 18'sd300;
  localparam logic signed [17:0] TEMP_MIN    = -18'sd1100;
  localparam logic signed [17:0] TEMP_MAX    = 18'sd1900;

  // one item travelling down the square root chain
  typedef struct packed {
    logic              valid;
    logic [MV_W-1:0]   mv;
    logic [DISC_W-1:0] rem;
    logic [DISC_W-1:0] res;
  } sqrt_lane_t;

endpackage

// ===== rtl/svt_front.sv =====
// front end: code to millivolts and millivolts to discriminant
module svt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [11:0]              adc_code_i,
  output svt_pkg::sqrt_lane_t      lane_o
);
  import svt_pkg::*;

  localparam logic [24:0] MV_DIV = 25'd4095;

  logic [2:0]        valid_q;
  logic [23:0]       x_d, x_q;
  logic [24:0]       est_sum;
  logic [12:0]       q_est;
  logic [24:0]       q_rem;
  logic [MV_W-1:0]   mv_d, mv_q;
  logic [MV_W-1:0]   mv3_q;
  logic [29:0]       k1_mv;
  logic [DISC_W-1:0] disc_d, disc_q;

  assign x_d = 24'(adc_code_i) * 24'(MV_SCALE);

  // divide by 2^12 - 1: estimate is never high and at most one low
  always_comb begin
    est_sum = 25'(x_q) + 25'(x_q >> 12);
    q_est   = est_sum[24:12];
    q_rem   = 25'(x_q) - {q_est, 12'b0} + 25'(q_est);
    mv_d    = 12'(q_est) + 12'(q_rem >= MV_DIV);
  end

  assign k1_mv  = 30'(DISC_K1) * 30'(mv_q);
  assign disc_d = DISC_K0 - 32'(k1_mv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    mv_q   <= mv_d;
    mv3_q  <= mv_q;
    disc_q <= disc_d;
  end

  assign lane_o = '{valid: valid_q[2], mv: mv3_q, rem: disc_q, res: '0};

endmodule

// ===== rtl/svt_sqrt_cell.sv =====
// one restoring square root step, two radicand bits per cell
module svt_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svt_pkg::sqrt_lane_t lane_i,
  output svt_pkg::sqrt_lane_t lane_o
);
  import svt_pkg::*;

  localparam logic [DISC_W-1:0] BIT = DISC_W'(1) << (DISC_W - 2 - 2 * STEP);

  logic              valid_q;
  logic [MV_W-1:0]   mv_q;
  logic [DISC_W-1:0] rem_d, rem_q;
  logic [DISC_W-1:0] res_d, res_q;
  logic [DISC_W:0]   trial;
  logic              take;

  always_comb begin
    trial = {1'b0, lane_i.res} + {1'b0, BIT};
    take  = {1'b0, lane_i.rem} >= trial;
    if (take) begin
      rem_d = lane_i.rem - trial[DISC_W-1:0];
      res_d = (lane_i.res >> 1) + BIT;
    end else begin
      rem_d = lane_i.rem;
      res_d = lane_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lane_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q  <= lane_i.mv;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign lane_o = '{valid: valid_q, mv: mv_q, rem: rem_q, res: res_q};

endmodule

// ===== rtl/svt_back.sv =====
// back end: rounded root to temperature in tenths, output register
module svt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svt_pkg::sqrt_lane_t lane_i,
  output logic                done_o,
  output logic [11:0]         millivolts_o,
  output logic signed [11:0]  temp_tenths_o
);
  import svt_pkg::*;

  logic [BACK_STAGES-1:0] valid_q;

  logic [ROOT_W-1:0]      root_d, root_q;
  logic [MV_W-1:0]        mv1_q, mv2_q, mv3_q, mv4_q, mv5_q, mv6_q;

  logic signed [29:0]     num;
  logic                   neg_d, neg2_q, neg3_q, neg4_q, neg5_q;
  logic signed [29:0]     num_abs;
  logic [27:0]            mag_d, mag_q;

  logic [47:0]            scaled;
  logic [24:0]            z_d, z_q, z4_q;

  logic [48:0]            q_prod;
  logic [15:0]            qe_d, qe_q;

  logic [25:0]            q_mul;
  logic [25:0]            q_rem;
  logic [15:0]            q_d, q_q;

  logic signed [17:0]     q_ext;
  logic signed [17:0]     temp_raw;
  logic signed [17:0]     temp_clamped;
  logic signed [11:0]     temp_q;

  // round to nearest root
  assign root_d = ROOT_W'(lane_i.res) + ROOT_W'(lane_i.rem > lane_i.res);

  // numerator in q24, split into sign and magnitude
  always_comb begin
    num     = $signed({1'b0, root_q, 12'b0}) - $signed({1'b0, A_Q24});
    neg_d   = num[29];
    num_abs = neg_d ? -num : num;
    mag_d   = num_abs[27:0];
  end

  // nested floor: first by 2^24, rounding half folded in, then by 694
  always_comb begin
    scaled = 48'(mag_q) * 48'(TEMP_SCALE);
    z_d    = 25'(scaled >> 24) + 25'(TEMP_HALF);
  end

  assign q_prod = 49'(z_q) * 49'(TEMP_RECIP);
  assign qe_d   = 16'(q_prod >> RECIP_SHIFT);

  // reciprocal estimate is at most one low
  always_comb begin
    q_mul = 26'(qe_q) * 26'(TEMP_DIV);
    q_rem = 26'(z4_q) - q_mul;
    q_d   = qe_q + 16'(q_rem >= 26'(TEMP_DIV));
  end

  always_comb begin
    q_ext    = $signed({2'b00, q_q});
    temp_raw = neg5_q ? (TEMP_OFFSET - q_ext) : (TEMP_OFFSET + q_ext);
    if (temp_raw < TEMP_MIN) begin
      temp_clamped = TEMP_MIN;
    end else if (temp_raw > TEMP_MAX) begin
      temp_clamped = TEMP_MAX;
    end else begin
      temp_clamped = temp_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[BACK_STAGES-2:0], lane_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    mv1_q  <= lane_i.mv;
    mag_q  <= mag_d;
    neg2_q <= neg_d;
    mv2_q  <= mv1_q;
    z_q    <= z_d;
    neg3_q <= neg2_q;
    mv3_q  <= mv2_q;
    qe_q   <= qe_d;
    z4_q   <= z_q;
    neg4_q <= neg3_q;
    mv4_q  <= mv3_q;
    q_q    <= q_d;
    neg5_q <= neg4_q;
    mv5_q  <= mv4_q;
    temp_q <= temp_clamped[11:0];
    mv6_q  <= mv5_q;
  end

  assign done_o        = valid_q[BACK_STAGES-1];
  assign millivolts_o  = mv6_q;
  assign temp_tenths_o = temp_q;

endmodule

// ===== rtl/sensor_voltage_to_temperature.sv =====
// top level: adc code to millivolts and temperature in tenths of a degree
// Takes one adc code per clock: busy_o is always low, so every cycle with
// start_i high accepts an item. Each item produces exactly one result,
// shown for one cycle with done_o high; results leave in acceptance
// order and cannot be held off, so capture them when done_o is seen.
// Each item passes through three front stages (scaling, divide by 4095,
// discriminant), the 16-cell square root chain (one result bit per
// cell) and six back stages (root rounding, constant multiplies and the
// divide by 694, clamp and output register).
module sensor_voltage_to_temperature (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [11:0]        adc_code_i,
  output logic               done_o,
  output logic [11:0]        millivolts_o,
  output logic signed [11:0] temp_tenths_o
);
  import svt_pkg::*;

  sqrt_lane_t lane [SQRT_STEPS+1];

  assign busy_o = 1'b0;

  svt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i),
    .adc_code_i (adc_code_i),
    .lane_o     (lane[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
    svt_sqrt_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (lane[i]),
      .lane_o (lane[i+1])
    );
  end

  svt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lane_i        (lane[SQRT_STEPS]),
    .done_o        (done_o),
    .millivolts_o  (millivolts_o),
    .temp_tenths_o (temp_tenths_o)
  );

endmodule

// ===== rtl/svt_checker.sv =====
// port-level checks for the converter and their bind to the top level
module svt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [11:0]        adc_code_i,
  input logic               done_o,
  input logic [11:0]        millivolts_o,
  input logic signed [11:0] temp_tenths_o
);
  import svt_pkg::*;

  // every accepted item returns after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted item did not return on time");

  // no result without an item accepted the latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching item");

  a_mv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (millivolts_o <= 12'd3220))
    else $error("millivolts above full scale");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (temp_tenths_o >= -12'sd1100 && temp_tenths_o <= 12'sd1900))
    else $error("temperature outside clamp range");

endmodule

bind sensor_voltage_to_temperature svt_checker u_svt_checker (.*);
